// File: rtl/core/fcmh_pkg.sv
// Shared types, constants and helpers for the frequency-count max-heap.
package fcmh_pkg;

	localparam int CAPACITY = 8;
	localparam int KEY_BITS = 32;
	localparam int KEY_W    = 32;
	localparam int COUNT_W  = 16;
	localparam int SIZE_W   = 4;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int TOTAL_W  = $clog2(CAPACITY + 1);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [TOTAL_W-1:0]  total_t;

	typedef enum logic [1:0] {
		ST_NEW  = 2'd0,
		ST_INC  = 2'd1,
		ST_NULL = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		key_t   key;
		count_t count;
	} entry_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		logic   re;
		idx_t   raddr;
	} mem_req_t;

	typedef struct packed {
		logic    done;
		status_t status;
		total_t  total;
	} seq_res_t;

	function automatic idx_t parent_of(idx_t p);
		return idx_t'(p - idx_t'(1)) >> 1;
	endfunction

	function automatic key_t to_key(logic [KEY_W-1:0] k);
		return key_t'(k);
	endfunction

endpackage

// File: rtl/core/fcmh_if.sv
// Valid/ready channel interfaces for request and result beats.
interface fcmh_req_if;
	import fcmh_pkg::*;
	logic             valid;
	logic             ready;
	logic             key_present;
	logic [KEY_W-1:0] location_key;

	modport source (output valid, output key_present, output location_key, input ready);
	modport sink   (input valid, input key_present, input location_key, output ready);
endinterface

interface fcmh_rsp_if;
	import fcmh_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [SIZE_W-1:0]  heap_size;
	logic [KEY_W-1:0]   top_key;
	logic [COUNT_W-1:0] top_count;

	modport source (output valid, output status, output heap_size, output top_key,
		output top_count, input ready);
	modport sink   (input valid, input status, input heap_size, input top_key,
		input top_count, output ready);
endinterface

// File: rtl/core/fcmh_store.sv
// Heap entry memory with one write and one registered read port, plus a root copy.
module fcmh_store (
	input  logic              clk,
	input  fcmh_pkg::mem_req_t mreq,
	output fcmh_pkg::entry_t  rdata,
	output fcmh_pkg::entry_t  root
);
	import fcmh_pkg::*;

	entry_t mem_q [CAPACITY];
	entry_t rdata_q;
	entry_t root_q;

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem_q[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata_q <= mem_q[mreq.raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (mreq.we && mreq.waddr == idx_t'(0)) begin
			root_q <= mreq.wdata;
		end
	end

	assign rdata = rdata_q;
	assign root  = root_q;

endmodule

// File: rtl/core/fcmh_seq.sv
// Sequencer: linear key search and sift-up through the shared compare and memory port.
module fcmh_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       key_present,
	input  logic [fcmh_pkg::KEY_W-1:0] location_key,
	input  logic                       out_free,
	input  fcmh_pkg::entry_t           rdata,
	output fcmh_pkg::mem_req_t         mreq,
	output fcmh_pkg::seq_res_t         res
);
	import fcmh_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_CMP    = 5'b00100,
		S_FIN    = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t  state_q, state_d;
	key_t    key_q, key_d;
	idx_t    idx_q, idx_d;
	idx_t    pos_q, pos_d;
	entry_t  cur_q, cur_d;
	total_t  total_q, total_d;
	status_t status_q, status_d;
	logic    sift_go;
	idx_t    sift_pos;
	idx_t    up;

	assign up        = parent_of(pos_q);
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		key_d    = key_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		cur_d    = cur_q;
		total_d  = total_q;
		status_d = status_q;
		sift_go  = 1'b0;
		sift_pos = pos_q;
		mreq     = '0;
		res      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_d = to_key(location_key);
					if (!key_present) begin
						status_d = ST_NULL;
						state_d  = S_DONE;
					end else if (total_q == total_t'(0)) begin
						cur_d    = '{key: to_key(location_key), count: count_t'(1)};
						total_d  = total_q + total_t'(1);
						status_d = ST_NEW;
						sift_go  = 1'b1;
						sift_pos = idx_t'(0);
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = idx_t'(0);
						idx_d      = idx_t'(0);
						state_d    = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (rdata.key == key_q) begin
					cur_d.key   = rdata.key;
					cur_d.count = (rdata.count == '1) ? rdata.count
						: rdata.count + count_t'(1);
					status_d    = ST_INC;
					sift_go     = 1'b1;
					sift_pos    = idx_q;
				end else if (total_t'(idx_q) + total_t'(1) == total_q) begin
					if (total_q == total_t'(CAPACITY)) begin
						status_d = ST_FULL;
						state_d  = S_DONE;
					end else begin
						cur_d    = '{key: key_q, count: count_t'(1)};
						total_d  = total_q + total_t'(1);
						status_d = ST_NEW;
						sift_go  = 1'b1;
						sift_pos = idx_t'(total_q);
					end
				end else begin
					idx_d      = idx_q + idx_t'(1);
					mreq.re    = 1'b1;
					mreq.raddr = idx_q + idx_t'(1);
				end
			end
			S_CMP: begin
				if (rdata.count >= cur_q.count) begin
					state_d = S_FIN;
				end else begin
					mreq.we    = 1'b1;
					mreq.waddr = pos_q;
					mreq.wdata = rdata;
					pos_d      = up;
					if (up == idx_t'(0)) begin
						state_d = S_FIN;
					end else begin
						mreq.re    = 1'b1;
						mreq.raddr = parent_of(up);
					end
				end
			end
			S_FIN: begin
				mreq.we    = 1'b1;
				mreq.waddr = pos_q;
				mreq.wdata = cur_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					res.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (sift_go) begin
			pos_d = sift_pos;
			if (sift_pos == idx_t'(0)) begin
				state_d = S_FIN;
			end else begin
				mreq.re    = 1'b1;
				mreq.raddr = parent_of(sift_pos);
				state_d    = S_CMP;
			end
		end
		res.status = status_q;
		res.total  = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q    <= key_d;
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		cur_q    <= cur_d;
		status_q <= status_d;
	end

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= total_t'(CAPACITY))
		else $error("entry total above capacity");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> out_free)
		else $error("result issued while output register busy");
	a_cmp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (pos_q != idx_t'(0)))
		else $error("sift compare at root");
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != $past(total_q)) |-> (total_q == $past(total_q) + total_t'(1)))
		else $error("entry total moved by more than one");
`endif

endmodule

// File: rtl/core/frequency_count_max_heap.sv
// Top level of the frequency-count max-heap with its result register.
//
//  channel | dir | beat payload
//  req     | in  | key_present, location_key
//  rsp     | out | status, heap_size, top_key, top_count
//
// A present key in a non-empty heap is searched linearly at one entry per cycle
// through the single memory read port; a hit or new entry then takes one compare per
// sift-up level and a final write, and every request ends by loading the result register.
// Reset clears the sequencer and entry total; entries are rewritten before use.
// A new request is taken while a result still waits in the result register;
// the sequencer stalls at its end only if that register is still occupied.
module frequency_count_max_heap (
	input  logic              clk,
	input  logic              arst_n,
	fcmh_req_if.sink          req,
	fcmh_rsp_if.source        rsp
);
	import fcmh_pkg::*;

	mem_req_t mreq;
	entry_t   rdata;
	entry_t   root;
	seq_res_t res;
	logic     out_free;

	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [SIZE_W-1:0]  size_q;
	logic [KEY_W-1:0]   top_key_q;
	logic [COUNT_W-1:0] top_count_q;

	assign out_free = !out_valid_q || rsp.ready;

	fcmh_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req.valid),
		.req_ready    (req.ready),
		.key_present  (req.key_present),
		.location_key (req.location_key),
		.out_free     (out_free),
		.rdata        (rdata),
		.mreq         (mreq),
		.res          (res)
	);

	fcmh_store u_store (
		.clk   (clk),
		.mreq  (mreq),
		.rdata (rdata),
		.root  (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			status_q <= res.status;
			size_q   <= SIZE_W'(res.total);
			if (res.total == total_t'(0)) begin
				top_key_q   <= '0;
				top_count_q <= '0;
			end else begin
				top_key_q   <= KEY_W'(root.key);
				top_count_q <= root.count;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.heap_size = size_q;
	assign rsp.top_key   = top_key_q;
	assign rsp.top_count = top_count_q;

endmodule

// File: verif/frequency_count_max_heap_test.sv
// Testbench for frequency_count_max_heap: directed table and random keys.
module frequency_count_max_heap_test;
	import fcmh_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [SIZE_W-1:0]   size;
		logic [KEY_W-1:0]    top_key;
		count_t              top_count;
	} heap_view_t;

	typedef struct {
		bit               present;
		logic [KEY_W-1:0] key;
		bit               typed;
		heap_view_t       view;
	} table_row_t;

	logic clk;
	logic arst_n;

	fcmh_req_if req();
	fcmh_rsp_if rsp();

	frequency_count_max_heap DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predicted heap contents
	key_t       heap_key [CAPACITY];
	count_t     heap_cnt [CAPACITY];
	int         heap_held;

	heap_view_t view_q [$];
	table_row_t steps [$];

	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int holds_done;
	int hold_left;
	int errors;
	int mismatches;
	int beats_seen;
	int status_seen [4];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic heap_view_t heap_update(bit present, logic [KEY_W-1:0] raw);
		key_t       k;
		int         pos;
		int         up;
		int         i;
		bit         hit;
		key_t       tk;
		count_t     tc;
		heap_view_t r;
		k   = key_t'(raw);
		pos = 0;
		hit = 1'b0;
		if (!present) begin
			r.status = ST_NULL;
		end else begin
			for (i = 0; i < heap_held; i++)
				if (!hit && heap_key[i] == k) begin
					hit = 1'b1;
					pos = i;
				end
			if (!hit && heap_held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				if (hit) begin
					if (heap_cnt[pos] != '1)
						heap_cnt[pos] = heap_cnt[pos] + 1'b1;
					r.status = ST_INC;
				end else begin
					pos = heap_held;
					heap_key[pos] = k;
					heap_cnt[pos] = count_t'(1);
					heap_held++;
					r.status = ST_NEW;
				end
				// sift up; ties stay put
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (heap_cnt[up] >= heap_cnt[pos])
						break;
					tk = heap_key[up];
					tc = heap_cnt[up];
					heap_key[up]  = heap_key[pos];
					heap_cnt[up]  = heap_cnt[pos];
					heap_key[pos] = tk;
					heap_cnt[pos] = tc;
					pos = up;
				end
			end
		end
		r.size      = SIZE_W'(heap_held);
		r.top_key   = (heap_held > 0) ? KEY_W'(heap_key[0]) : '0;
		r.top_count = (heap_held > 0) ? heap_cnt[0] : '0;
		status_seen[r.status]++;
		return r;
	endfunction

	// drive one beat, wait for acceptance, then predict
	task automatic drive_beat(input bit present, input logic [KEY_W-1:0] k,
		output heap_view_t v);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid        <= 1'b1;
		req.key_present  <= present;
		req.location_key <= k;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		v = heap_update(present, k);
	endtask

	task automatic drain;
		req.valid <= 1'b0;
		while (view_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 0;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_asked;
			hold_left  <= 400;
			rsp.ready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		heap_view_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			beats_seen++;
			if (view_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: status %0d size %0d key %h count %0d",
						rsp.status, rsp.heap_size, rsp.top_key, rsp.top_count);
			end else begin
				want = view_q.pop_front();
				if (rsp.status !== want.status || rsp.heap_size !== want.size ||
					rsp.top_key !== want.top_key || rsp.top_count !== want.top_count) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d mismatch: exp st %0d sz %0d key %h cnt %0d, got st %0d sz %0d key %h cnt %0d",
							beats_seen, want.status, want.size, want.top_key, want.top_count,
							rsp.status, rsp.heap_size, rsp.top_key, rsp.top_count);
				end
			end
		end
	end

	initial begin
		heap_view_t v;
		int         phase;
		int         sent;
		int         pick;
		bit         present;
		logic [KEY_W-1:0] k;

		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.key_present  = 1'b0;
		req.location_key = '0;
		send_idle_pct    = 0;
		recv_idle_pct    = 0;
		holds_asked      = 0;
		errors           = 0;
		mismatches       = 0;
		beats_seen       = 0;
		heap_held        = 0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;

		steps.push_back('{1'b0, 32'h0000_0000, 1'b1, '{ST_NULL, 4'd0, 32'h0, 16'd0}});
		steps.push_back('{1'b0, 32'hFFFF_FFFF, 1'b1, '{ST_NULL, 4'd0, 32'h0, 16'd0}});
		steps.push_back('{1'b1, 32'h0000_0000, 1'b1, '{ST_NEW, 4'd1, 32'h0, 16'd1}});
		steps.push_back('{1'b1, 32'hFFFF_FFFF, 1'b0, '0});
		steps.push_back('{1'b1, 32'hFFFF_FFFF, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0001, 1'b0, '0});
		steps.push_back('{1'b1, 32'h8000_0000, 1'b0, '0});
		steps.push_back('{1'b1, 32'h5555_5555, 1'b0, '0});
		steps.push_back('{1'b1, 32'hAAAA_AAAA, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0002, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0004, 1'b0, '0});
		steps.push_back('{1'b1, 32'h1234_5678, 1'b1, '{ST_FULL, 4'd8, 32'hFFFF_FFFF, 16'd2}});
		steps.push_back('{1'b0, 32'hA5A5_A5A5, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0004, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0004, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0004, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0004, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0000, 1'b0, '0});
		steps.push_back('{1'b1, 32'h0000_0001, 1'b0, '0});
		steps.push_back('{1'b1, 32'h7FFF_FFFF, 1'b0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			drive_beat(steps[i].present, steps[i].key, v);
			view_q.push_back(steps[i].typed ? steps[i].view : v);
		end

		// mostly held keys, some unknown keys (full rejects) and null beats
		for (phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 21 : 0;
			sent = 0;
			while (sent < 440) begin
				pick    = $urandom_range(99);
				present = (pick >= 10) || $urandom_range(1);
				k       = $urandom;
				if (pick >= 25 && heap_held > 0)
					k = KEY_W'(heap_key[$urandom_range(heap_held - 1)]);
				drive_beat(present, k, v);
				view_q.push_back(v);
				sent++;
				if (sent == 120 && phase != 1)
					holds_asked++;
				if (sent == 300)
					drain();
			end
		end

		// final burst over held keys
		for (int i = 0; i < 20; i++) begin
			drive_beat(1'b1, KEY_W'(heap_key[$urandom_range(CAPACITY - 1)]), v);
			view_q.push_back(v);
		end

		req.valid <= 1'b0;
		while (view_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Checked %0d result beats: %0d new, %0d incremented, %0d null, %0d full.",
			beats_seen, status_seen[ST_NEW], status_seen[ST_INC], status_seen[ST_NULL],
			status_seen[ST_FULL]);
		$display("Run included a full heap, a long result stall and an idle drain.");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
